FILE: src/ccl_pkg.sv
// ----------------------------------------------------------------------------
// ccl_pkg: code point classifier shared definitions
// Class codes, pipeline stage record and the fixed range table that is
// searched for code points at or above 0x100.
// ----------------------------------------------------------------------------
`default_nettype none
package ccl_pkg;

    localparam int CP_W    = 21;
    localparam int CLASS_W = 4;
    localparam int POS_W   = 9;
    localparam int IDX_W   = 8;

    localparam logic [CLASS_W-1:0] CL_SPACE   = 4'd0;
    localparam logic [CLASS_W-1:0] CL_PUNCT   = 4'd1;
    localparam logic [CLASS_W-1:0] CL_WORD    = 4'd2;
    localparam logic [CLASS_W-1:0] CL_EMOJI   = 4'd3;
    localparam logic [CLASS_W-1:0] CL_SUPER   = 4'd4;
    localparam logic [CLASS_W-1:0] CL_SUB     = 4'd5;
    localparam logic [CLASS_W-1:0] CL_BRAILLE = 4'd6;
    localparam logic [CLASS_W-1:0] CL_HIRA    = 4'd7;
    localparam logic [CLASS_W-1:0] CL_KATA    = 4'd8;
    localparam logic [CLASS_W-1:0] CL_CJK     = 4'd9;
    localparam logic [CLASS_W-1:0] CL_HANGUL  = 4'd10;

    localparam logic [CP_W-1:0] LOW_LIMIT = 21'h00100;

    typedef struct packed {
        logic [CP_W-1:0]    lo;
        logic [CP_W-1:0]    hi;
        logic [CLASS_W-1:0] cls;
    } range_entry_t;

    // One search step in flight: the window is [first, end_idx).
    typedef struct packed {
        logic [CP_W-1:0]    cp;
        logic [POS_W-1:0]   first;
        logic [POS_W-1:0]   end_idx;
        logic               done;
        logic [CLASS_W-1:0] cls;
    } stage_t;

    localparam int RANGE_ROM_LEN = 218;

    localparam range_entry_t RANGE_ROM [RANGE_ROM_LEN] = '{
        '{21'h0037e,21'h0037e,CL_PUNCT},'{21'h00387,21'h00387,CL_PUNCT},
        '{21'h0055a,21'h0055f,CL_PUNCT},'{21'h00589,21'h00589,CL_PUNCT},
        '{21'h005be,21'h005be,CL_PUNCT},'{21'h005c0,21'h005c0,CL_PUNCT},
        '{21'h005c3,21'h005c3,CL_PUNCT},'{21'h005f3,21'h005f4,CL_PUNCT},
        '{21'h0060c,21'h0060c,CL_PUNCT},'{21'h0061b,21'h0061b,CL_PUNCT},
        '{21'h0061f,21'h0061f,CL_PUNCT},'{21'h0066a,21'h0066d,CL_PUNCT},
        '{21'h006d4,21'h006d4,CL_PUNCT},'{21'h00700,21'h0070d,CL_PUNCT},
        '{21'h00964,21'h00965,CL_PUNCT},'{21'h00970,21'h00970,CL_PUNCT},
        '{21'h00df4,21'h00df4,CL_PUNCT},'{21'h00e4f,21'h00e4f,CL_PUNCT},
        '{21'h00e5a,21'h00e5b,CL_PUNCT},'{21'h00f04,21'h00f12,CL_PUNCT},
        '{21'h00f3a,21'h00f3d,CL_PUNCT},'{21'h00f85,21'h00f85,CL_PUNCT},
        '{21'h0104a,21'h0104f,CL_PUNCT},'{21'h010fb,21'h010fb,CL_PUNCT},
        '{21'h01361,21'h01368,CL_PUNCT},'{21'h0166d,21'h0166e,CL_PUNCT},
        '{21'h01680,21'h01680,CL_SPACE},'{21'h0169b,21'h0169c,CL_PUNCT},
        '{21'h016eb,21'h016ed,CL_PUNCT},'{21'h01735,21'h01736,CL_PUNCT},
        '{21'h017d4,21'h017dc,CL_PUNCT},'{21'h01800,21'h0180a,CL_PUNCT},
        '{21'h02000,21'h0200b,CL_SPACE},'{21'h0200c,21'h02027,CL_PUNCT},
        '{21'h02028,21'h02029,CL_SPACE},'{21'h0202a,21'h0202e,CL_PUNCT},
        '{21'h0202f,21'h0202f,CL_SPACE},'{21'h02030,21'h0205e,CL_PUNCT},
        '{21'h0203c,21'h0203c,CL_EMOJI},'{21'h02049,21'h02049,CL_EMOJI},
        '{21'h0205f,21'h0205f,CL_SPACE},'{21'h02060,21'h027ff,CL_PUNCT},
        '{21'h02070,21'h0207f,CL_SUPER},'{21'h02080,21'h02094,CL_SUB},
        '{21'h020a0,21'h027ff,CL_PUNCT},'{21'h02122,21'h02122,CL_EMOJI},
        '{21'h02139,21'h02139,CL_EMOJI},'{21'h02194,21'h02199,CL_EMOJI},
        '{21'h021a9,21'h021aa,CL_EMOJI},'{21'h0231a,21'h0231b,CL_EMOJI},
        '{21'h02328,21'h02328,CL_EMOJI},'{21'h023cf,21'h023cf,CL_EMOJI},
        '{21'h023e9,21'h023f3,CL_EMOJI},'{21'h023f8,21'h023fa,CL_EMOJI},
        '{21'h024c2,21'h024c2,CL_EMOJI},'{21'h025aa,21'h025ab,CL_EMOJI},
        '{21'h025b6,21'h025b6,CL_EMOJI},'{21'h025c0,21'h025c0,CL_EMOJI},
        '{21'h025fb,21'h025fe,CL_EMOJI},'{21'h02600,21'h02604,CL_EMOJI},
        '{21'h0260e,21'h0260e,CL_EMOJI},'{21'h02611,21'h02611,CL_EMOJI},
        '{21'h02614,21'h02615,CL_EMOJI},'{21'h02618,21'h02618,CL_EMOJI},
        '{21'h0261d,21'h0261d,CL_EMOJI},'{21'h02620,21'h02620,CL_EMOJI},
        '{21'h02622,21'h02623,CL_EMOJI},'{21'h02626,21'h02626,CL_EMOJI},
        '{21'h0262a,21'h0262a,CL_EMOJI},'{21'h0262e,21'h0262f,CL_EMOJI},
        '{21'h02638,21'h0263a,CL_EMOJI},'{21'h02640,21'h02640,CL_EMOJI},
        '{21'h02642,21'h02642,CL_EMOJI},'{21'h02648,21'h02653,CL_EMOJI},
        '{21'h0265f,21'h02660,CL_EMOJI},'{21'h02663,21'h02663,CL_EMOJI},
        '{21'h02665,21'h02666,CL_EMOJI},'{21'h02668,21'h02668,CL_EMOJI},
        '{21'h0267b,21'h0267b,CL_EMOJI},'{21'h0267e,21'h0267f,CL_EMOJI},
        '{21'h02692,21'h02697,CL_EMOJI},'{21'h02699,21'h02699,CL_EMOJI},
        '{21'h0269b,21'h0269c,CL_EMOJI},'{21'h026a0,21'h026a1,CL_EMOJI},
        '{21'h026a7,21'h026a7,CL_EMOJI},'{21'h026aa,21'h026ab,CL_EMOJI},
        '{21'h026b0,21'h026b1,CL_EMOJI},'{21'h026bd,21'h026be,CL_EMOJI},
        '{21'h026c4,21'h026c5,CL_EMOJI},'{21'h026c8,21'h026c8,CL_EMOJI},
        '{21'h026ce,21'h026cf,CL_EMOJI},'{21'h026d1,21'h026d1,CL_EMOJI},
        '{21'h026d3,21'h026d4,CL_EMOJI},'{21'h026e9,21'h026ea,CL_EMOJI},
        '{21'h026f0,21'h026f5,CL_EMOJI},'{21'h026f7,21'h026fa,CL_EMOJI},
        '{21'h026fd,21'h026fd,CL_EMOJI},'{21'h02702,21'h02702,CL_EMOJI},
        '{21'h02705,21'h02705,CL_EMOJI},'{21'h02708,21'h0270d,CL_EMOJI},
        '{21'h0270f,21'h0270f,CL_EMOJI},'{21'h02712,21'h02712,CL_EMOJI},
        '{21'h02714,21'h02714,CL_EMOJI},'{21'h02716,21'h02716,CL_EMOJI},
        '{21'h0271d,21'h0271d,CL_EMOJI},'{21'h02721,21'h02721,CL_EMOJI},
        '{21'h02728,21'h02728,CL_EMOJI},'{21'h02733,21'h02734,CL_EMOJI},
        '{21'h02744,21'h02744,CL_EMOJI},'{21'h02747,21'h02747,CL_EMOJI},
        '{21'h0274c,21'h0274c,CL_EMOJI},'{21'h0274e,21'h0274e,CL_EMOJI},
        '{21'h02753,21'h02755,CL_EMOJI},'{21'h02757,21'h02757,CL_EMOJI},
        '{21'h02763,21'h02764,CL_EMOJI},'{21'h02795,21'h02797,CL_EMOJI},
        '{21'h027a1,21'h027a1,CL_EMOJI},'{21'h027b0,21'h027b0,CL_EMOJI},
        '{21'h027bf,21'h027bf,CL_EMOJI},'{21'h02800,21'h028ff,CL_BRAILLE},
        '{21'h02900,21'h02998,CL_PUNCT},'{21'h02934,21'h02935,CL_EMOJI},
        '{21'h029d8,21'h029db,CL_PUNCT},'{21'h029fc,21'h029fd,CL_PUNCT},
        '{21'h02b05,21'h02b07,CL_EMOJI},'{21'h02b1b,21'h02b1c,CL_EMOJI},
        '{21'h02b50,21'h02b50,CL_EMOJI},'{21'h02b55,21'h02b55,CL_EMOJI},
        '{21'h02e00,21'h02e7f,CL_PUNCT},'{21'h03000,21'h03000,CL_SPACE},
        '{21'h03001,21'h03020,CL_PUNCT},'{21'h03030,21'h03030,CL_EMOJI},
        '{21'h03030,21'h03030,CL_PUNCT},'{21'h0303d,21'h0303d,CL_EMOJI},
        '{21'h0303d,21'h0303d,CL_PUNCT},'{21'h03040,21'h0309f,CL_HIRA},
        '{21'h030a0,21'h030ff,CL_KATA},'{21'h03297,21'h03297,CL_EMOJI},
        '{21'h03299,21'h03299,CL_EMOJI},'{21'h03300,21'h09fff,CL_CJK},
        '{21'h0ac00,21'h0d7a3,CL_HANGUL},'{21'h0f900,21'h0faff,CL_CJK},
        '{21'h0fd3e,21'h0fd3f,CL_PUNCT},'{21'h0fe30,21'h0fe6b,CL_PUNCT},
        '{21'h0ff00,21'h0ff0f,CL_PUNCT},'{21'h0ff1a,21'h0ff20,CL_PUNCT},
        '{21'h0ff3b,21'h0ff40,CL_PUNCT},'{21'h0ff5b,21'h0ff65,CL_PUNCT},
        '{21'h1d000,21'h1d24f,CL_PUNCT},'{21'h1d400,21'h1d7ff,CL_PUNCT},
        '{21'h1f000,21'h1f2ff,CL_PUNCT},'{21'h1f004,21'h1f004,CL_EMOJI},
        '{21'h1f0cf,21'h1f0cf,CL_EMOJI},'{21'h1f170,21'h1f171,CL_EMOJI},
        '{21'h1f17e,21'h1f17f,CL_EMOJI},'{21'h1f18e,21'h1f18e,CL_EMOJI},
        '{21'h1f191,21'h1f19a,CL_EMOJI},'{21'h1f1e6,21'h1f1ff,CL_EMOJI},
        '{21'h1f201,21'h1f202,CL_EMOJI},'{21'h1f21a,21'h1f21a,CL_EMOJI},
        '{21'h1f22f,21'h1f22f,CL_EMOJI},'{21'h1f232,21'h1f23a,CL_EMOJI},
        '{21'h1f250,21'h1f251,CL_EMOJI},'{21'h1f300,21'h1f321,CL_EMOJI},
        '{21'h1f300,21'h1f9ff,CL_PUNCT},'{21'h1f324,21'h1f393,CL_EMOJI},
        '{21'h1f396,21'h1f397,CL_EMOJI},'{21'h1f399,21'h1f39b,CL_EMOJI},
        '{21'h1f39e,21'h1f3f0,CL_EMOJI},'{21'h1f3f3,21'h1f3f5,CL_EMOJI},
        '{21'h1f3f7,21'h1f4fd,CL_EMOJI},'{21'h1f4ff,21'h1f53d,CL_EMOJI},
        '{21'h1f549,21'h1f54e,CL_EMOJI},'{21'h1f550,21'h1f567,CL_EMOJI},
        '{21'h1f56f,21'h1f570,CL_EMOJI},'{21'h1f573,21'h1f57a,CL_EMOJI},
        '{21'h1f587,21'h1f587,CL_EMOJI},'{21'h1f58a,21'h1f58d,CL_EMOJI},
        '{21'h1f590,21'h1f590,CL_EMOJI},'{21'h1f595,21'h1f596,CL_EMOJI},
        '{21'h1f5a4,21'h1f5a5,CL_EMOJI},'{21'h1f5a8,21'h1f5a8,CL_EMOJI},
        '{21'h1f5b1,21'h1f5b2,CL_EMOJI},'{21'h1f5bc,21'h1f5bc,CL_EMOJI},
        '{21'h1f5c2,21'h1f5c4,CL_EMOJI},'{21'h1f5d1,21'h1f5d3,CL_EMOJI},
        '{21'h1f5dc,21'h1f5de,CL_EMOJI},'{21'h1f5e1,21'h1f5e1,CL_EMOJI},
        '{21'h1f5e3,21'h1f5e3,CL_EMOJI},'{21'h1f5e8,21'h1f5e8,CL_EMOJI},
        '{21'h1f5ef,21'h1f5ef,CL_EMOJI},'{21'h1f5f3,21'h1f5f3,CL_EMOJI},
        '{21'h1f5fa,21'h1f64f,CL_EMOJI},'{21'h1f680,21'h1f6c5,CL_EMOJI},
        '{21'h1f6cb,21'h1f6d2,CL_EMOJI},'{21'h1f6d5,21'h1f6d7,CL_EMOJI},
        '{21'h1f6e0,21'h1f6e5,CL_EMOJI},'{21'h1f6e9,21'h1f6e9,CL_EMOJI},
        '{21'h1f6eb,21'h1f6ec,CL_EMOJI},'{21'h1f6f0,21'h1f6f0,CL_EMOJI},
        '{21'h1f6f3,21'h1f6fc,CL_EMOJI},'{21'h1f7e0,21'h1f7eb,CL_EMOJI},
        '{21'h1f90c,21'h1f93a,CL_EMOJI},'{21'h1f93c,21'h1f945,CL_EMOJI},
        '{21'h1f947,21'h1f978,CL_EMOJI},'{21'h1f97a,21'h1f9cb,CL_EMOJI},
        '{21'h1f9cd,21'h1f9ff,CL_EMOJI},'{21'h1fa70,21'h1fa74,CL_EMOJI},
        '{21'h1fa78,21'h1fa7a,CL_EMOJI},'{21'h1fa80,21'h1fa86,CL_EMOJI},
        '{21'h1fa90,21'h1faa8,CL_EMOJI},'{21'h1fab0,21'h1fab6,CL_EMOJI},
        '{21'h1fac0,21'h1fac2,CL_EMOJI},'{21'h1fad0,21'h1fad6,CL_EMOJI},
        '{21'h20000,21'h2a6df,CL_CJK},'{21'h2a700,21'h2b73f,CL_CJK},
        '{21'h2b740,21'h2b81f,CL_CJK},'{21'h2f800,21'h2fa1f,CL_CJK}
    };

    // Fixed rule for code points below 0x100.
    function automatic logic [CLASS_W-1:0] low_class(input logic [7:0] c);
        logic [CLASS_W-1:0] r;
        if (c == 8'h20 || c == 8'h09 || c == 8'h00 || c == 8'hA0)
        begin
            r = CL_SPACE;
        end
        else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                 (c >= 8'h30 && c <= 8'h39) || c == 8'h5F ||
                 (c >= 8'h80 && c <= 8'hA7) || (c >= 8'hE0 && c <= 8'hEB))
        begin
            r = CL_WORD;
        end
        else
        begin
            r = CL_PUNCT;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/ccl_cp_if.sv
// ----------------------------------------------------------------------------
// ccl_cp_if: code point request channel
// Valid/ready channel that carries one code point per request.
// ----------------------------------------------------------------------------
`default_nettype none
interface ccl_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface
`default_nettype wire

FILE: src/ccl_class_if.sv
// ----------------------------------------------------------------------------
// ccl_class_if: character class result channel
// Valid/ready channel that carries one character class per request.
// ----------------------------------------------------------------------------
`default_nettype none
interface ccl_class_if;
    logic       valid;
    logic       ready;
    logic [3:0] char_class;

    modport source (output valid, output char_class, input ready);
    modport sink   (input valid, input char_class, output ready);
endinterface
`default_nettype wire

FILE: src/codepoint_class_lookup_core.sv
// ----------------------------------------------------------------------------
// codepoint_class_lookup_core: Unicode character class lookup
// Pipelined classifier: fixed rule below 0x100, binary range search above.
// ----------------------------------------------------------------------------
// Usage:
//   cp_in carries one code point per request; class_out returns its class
//   (0 space ... 10 hangul) in the same order, one result per request.
//   A request is taken in every cycle in which the pipeline can move, so the
//   sustained rate is one code point per clock.
//   STAGES = clog2(searched entries + 1) is the number of probes that a
//   binary search over the searched entries needs. Each search stage
//   performs one probe of the constant range table, so the number of
//   probes of the binary search sets the depth.
//   When class_out.ready is low while a result is held, the whole pipeline
//   freezes and cp_in.ready drops; nothing is lost or repeated.
//   Reset clears all valid bits; the block is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module codepoint_class_lookup_core #(
    parameter int RANGE_ENTRIES = 218
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ccl_cp_if.sink      cp_in,
    ccl_class_if.source class_out
);
    import ccl_pkg::*;

    localparam int SEARCH_N = (RANGE_ENTRIES > RANGE_ROM_LEN) ? RANGE_ROM_LEN
                                                               : RANGE_ENTRIES;
    localparam int STAGES   = $clog2(SEARCH_N + 1);

    stage_t stage_reg   [STAGES+1];
    stage_t stage_next  [STAGES+1];
    logic   [STAGES:0]  valid_reg;
    logic               adv;

    // The pipeline moves unless a held result is blocked.
    assign adv         = !valid_reg[STAGES] || class_out.ready;
    assign cp_in.ready = adv;

    // Entry stage: low code points resolve at once, others open the search.
    always_comb
    begin
        stage_next[0].cp      = cp_in.code_point;
        stage_next[0].first   = '0;
        stage_next[0].end_idx = POS_W'(SEARCH_N);
        if (cp_in.code_point < LOW_LIMIT)
        begin
            stage_next[0].done = 1'b1;
            stage_next[0].cls  = low_class(cp_in.code_point[7:0]);
        end
        else
        begin
            stage_next[0].done = 1'b0;
            stage_next[0].cls  = CL_WORD;
        end
    end

    // One probe of the range table in each search stage.
    for (genvar k = 1; k <= STAGES; k++)
    begin : g_probe
        logic [POS_W-1:0] mid;
        range_entry_t     ent;

        assign mid = POS_W'((stage_reg[k-1].first + stage_reg[k-1].end_idx
                             - POS_W'(1)) >> 1);
        assign ent = RANGE_ROM[mid[IDX_W-1:0]];

        always_comb
        begin
            stage_next[k] = stage_reg[k-1];
            if (!stage_reg[k-1].done &&
                stage_reg[k-1].first < stage_reg[k-1].end_idx)
            begin
                if (stage_reg[k-1].cp < ent.lo)
                begin
                    stage_next[k].end_idx = mid;
                end
                else if (ent.hi < stage_reg[k-1].cp)
                begin
                    stage_next[k].first = mid + POS_W'(1);
                end
                else
                begin
                    stage_next[k].done = 1'b1;
                    stage_next[k].cls  = ent.cls;
                end
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[STAGES-1:0], cp_in.valid};
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= STAGES; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign class_out.valid      = valid_reg[STAGES];
    assign class_out.char_class = stage_reg[STAGES].cls;

    // A result always carries a defined class code.
    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STAGES] |-> stage_reg[STAGES].cls <= CL_HANGUL)
        else $error("class code out of range");

    // An unresolved search must have an empty window at the last stage.
    a_search_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STAGES] && !stage_reg[STAGES].done) |->
        (stage_reg[STAGES].first >= stage_reg[STAGES].end_idx &&
         stage_reg[STAGES].cls == CL_WORD))
        else $error("search window not exhausted");

    // Low code points resolve in the entry stage.
    a_low_done: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && stage_reg[0].cp < LOW_LIMIT) |-> stage_reg[0].done)
        else $error("low code point not resolved");

    // A blocked result is held until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STAGES] && !class_out.ready) |=>
        (valid_reg[STAGES] && $stable(stage_reg[STAGES].cls)))
        else $error("blocked result changed");

endmodule
`default_nettype wire

FILE: bench/tb_codepoint_class_lookup_core.sv
// ----------------------------------------------------------------------------
// tb_codepoint_class_lookup_core: self-checking bench for the class lookup
// Sends code points through the request channel and checks every returned
// class against an in-bench classifier (fixed rule below 0x100, binary
// search over the package range table above), in order, with random
// idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_codepoint_class_lookup_core;
    import ccl_pkg::*;

    localparam int SEARCH_LEN = 218;
    localparam int RANDOM_REQS = 2000;
    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ccl_cp_if    cp_ch ();
    ccl_class_if class_ch ();

    codepoint_class_lookup_core #(.RANGE_ENTRIES(SEARCH_LEN)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cp_in     (cp_ch),
        .class_out (class_ch)
    );

    always #5 clk = ~clk;

    logic [CP_W-1:0]    pending_cps[$];
    logic [CLASS_W-1:0] expected_classes[$];
    int                 errors = 0;
    int                 cycle_count = 0;
    int                 checked = 0;
    int                 stall_left = 0;
    bit                 stall_used = 1'b0;
    bit                 calm = 1'b0;

    // Class of one code point, computed independently of the block.
    function automatic logic [CLASS_W-1:0] classify(input logic [CP_W-1:0] cp);
        int lo_i;
        int hi_i;
        int mid;
        logic [7:0] c;
        if (cp < 21'h100)
        begin
            c = cp[7:0];
            if (c == 8'h20 || c == 8'h09 || c == 8'h00 || c == 8'hA0)
                return CL_SPACE;
            if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                (c >= 8'h30 && c <= 8'h39) || c == 8'h5F ||
                (c >= 8'h80 && c <= 8'hA7) || (c >= 8'hE0 && c <= 8'hEB))
                return CL_WORD;
            return CL_PUNCT;
        end
        lo_i = 0;
        hi_i = SEARCH_LEN - 1;
        while (lo_i <= hi_i)
        begin
            mid = lo_i + (hi_i - lo_i) / 2;
            if (cp < RANGE_ROM[mid].lo)
                hi_i = mid - 1;
            else if (RANGE_ROM[mid].hi < cp)
                lo_i = mid + 1;
            else
                return RANGE_ROM[mid].cls;
        end
        return CL_WORD;
    endfunction

    // Random code point, mostly near table ranges to reach the deep probes.
    function automatic logic [CP_W-1:0] pick_cp();
        int k;
        int e;
        k = $urandom_range(0, 99);
        e = $urandom_range(0, SEARCH_LEN - 1);
        if (k < 15)
            return CP_W'($urandom_range(0, 255));
        else if (k < 60)
            return CP_W'(RANGE_ROM[e].lo
                         + $urandom_range(0, RANGE_ROM[e].hi - RANGE_ROM[e].lo));
        else if (k < 75)
            return CP_W'(RANGE_ROM[e].lo - 1);
        else if (k < 85)
            return CP_W'(RANGE_ROM[e].hi + 1);
        else if (k < 95)
            return CP_W'($urandom_range(21'h100, 21'h10FFFF));
        return CP_W'($urandom_range(0, 21'h1FFFFF));
    endfunction

    // Fill the request queue: directed corners first, then random.
    initial
    begin
        logic [CP_W-1:0] directed[$];
        directed = '{21'h0, 21'h09, 21'h20, 21'hA0, 21'h41, 21'h7A, 21'h5F, 21'h2F,
                     21'h80, 21'hA7, 21'hA8, 21'hE0, 21'hEB, 21'hFF, 21'h100,
                     21'h3030, 21'h303D, 21'h2070, 21'h2122, 21'h1680, 21'h10FFFF,
                     21'h1FFFFF, 21'h2FA1F, 21'h1F300, 21'h155555};
        foreach (directed[i])
            pending_cps.push_back(directed[i]);
        for (int i = 0; i < RANDOM_REQS; i++)
            pending_cps.push_back(pick_cp());
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: offers requests with random gaps; predicts on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_ch.valid <= 1'b0;
            cp_ch.code_point <= '0;
        end
        else
        begin
            if (cp_ch.valid && cp_ch.ready)
                expected_classes.push_back(classify(cp_ch.code_point));
            if ((cp_ch.valid && !cp_ch.ready) || pending_cps.size() == 0)
            begin
                if (pending_cps.size() == 0 && cp_ch.ready)
                    cp_ch.valid <= 1'b0;
            end
            else if (calm || $urandom_range(0, 99) >= 15)
            begin
                cp_ch.valid <= 1'b1;
                cp_ch.code_point <= pending_cps.pop_front();
            end
            else
                cp_ch.valid <= 1'b0;
        end
    end

    // Quiet stretch without idling in the middle of the run.
    always @(posedge clk)
        calm <= (pending_cps.size() > 800 && pending_cps.size() < 1200);

    // Receiver: random stalls plus one long hold-off to back up the pipeline.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            class_ch.ready <= 1'b0;
        else
        begin
            if (!stall_used && pending_cps.size() < 1600)
            begin
                stall_used <= 1'b1;
                stall_left <= 60;
                class_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                class_ch.ready <= (stall_left == 1);
            end
            else
                class_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && class_ch.valid && class_ch.ready)
        begin
            if (expected_classes.size() == 0)
            begin
                $error("char_class: unexpected result %0d", class_ch.char_class);
                errors++;
            end
            else
            begin
                if (class_ch.char_class !== expected_classes[0])
                begin
                    $error("char_class: expected %0d, actual %0d",
                           expected_classes[0], class_ch.char_class);
                    errors++;
                end
                void'(expected_classes.pop_front());
                checked++;
            end
        end
    end

    // Cycle limit guards against a hung pipeline.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // End of run: drain, settle, report.
    initial
    begin
        wait (rst_n);
        wait (pending_cps.size() == 0 && cp_ch.valid == 1'b0);
        wait (expected_classes.size() == 0);
        repeat (20) @(posedge clk);
        $display("Checked %0d code point classifications, low rule and range search,",
                 checked);
        $display("including overlaps, misses past 0x10FFFF and a long output stall.");
        if (errors == 0 && expected_classes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
